@@ design/udepq_pkg.sv @@
// shared types and codes for the double-ended priority queue
// no dependencies; used by every module in this folder
`default_nettype none

package udepq_pkg;

  localparam int DATA_W = 32;
  localparam int OCC_W  = 7;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_MAX    = 2'd1;
  localparam logic [1:0] OP_MIN    = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic                     valid;
    logic signed [DATA_W-1:0] data;
  } cell_t;

  typedef struct packed {
    logic load;
    logic shift;
    logic insert;
    logic want_max;
  } scan_ctrl_t;

endpackage

`default_nettype wire

@@ design/udepq_cell.sv @@
// one storage cell of the rotating ring: a value and its occupied bit
// depends on udepq_pkg
`default_nettype none

module udepq_cell (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            shift,
  input  wire udepq_pkg::cell_t din,
  output udepq_pkg::cell_t     dout
);

  logic                                valid;
  logic signed [udepq_pkg::DATA_W-1:0] data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (shift) begin
      valid <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      data <= din.data;
    end
  end

  assign dout.valid = valid;
  assign dout.data  = data;

endmodule

`default_nettype wire

@@ design/udepq_head.sv @@
// head of the ring: holds the carried value, swaps it with passing
// cells on extract, fills the first free cell on insert; uses udepq_pkg
`default_nettype none

module udepq_head (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire udepq_pkg::scan_ctrl_t               ctrl,
  input  wire logic signed [udepq_pkg::DATA_W-1:0] value,
  input  wire udepq_pkg::cell_t                    ring_in,
  output udepq_pkg::cell_t                         ring_out,
  output logic                                     held_valid,
  output logic signed [udepq_pkg::DATA_W-1:0]      held_data
);

  logic                                held_valid_next;
  logic signed [udepq_pkg::DATA_W-1:0] held_data_next;
  logic                                better;

  assign better = ctrl.want_max ? (ring_in.data > held_data) : (ring_in.data < held_data);

  always_comb begin
    ring_out        = ring_in;
    held_valid_next = held_valid;
    held_data_next  = held_data;
    if (ctrl.insert) begin
      // drop the carried value into the first free cell
      if (held_valid && !ring_in.valid) begin
        ring_out.valid  = 1'b1;
        ring_out.data   = held_data;
        held_valid_next = 1'b0;
      end
    end else if (ring_in.valid) begin
      if (!held_valid) begin
        ring_out.valid  = 1'b0;
        held_valid_next = 1'b1;
        held_data_next  = ring_in.data;
      end else if (better) begin
        ring_out.data  = held_data;
        held_data_next = ring_in.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (ctrl.load) begin
      held_valid <= ctrl.insert;
    end else if (ctrl.shift) begin
      held_valid <= held_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      held_data <= value;
    end else if (ctrl.shift) begin
      held_data <= held_data_next;
    end
  end

endmodule

`default_nettype wire

@@ design/unsorted_double_ended_priority_queue_unit.sv @@
// double-ended priority queue: unsorted ring of DEPTH cells with a head swap unit
// insert and extract run S_IDLE, S_SCAN for one full ring rotation, then S_DONE, and the result is registered;
// full insert, empty extract and unused codes are answered straight from S_IDLE into the output register
// a new operation is taken only in S_IDLE, once the previous one is done and the output can accept it
// reset: synchronous; empties the queue, clears all cell occupied bits
// depends on udepq_pkg, udepq_cell, udepq_head
`default_nettype none

module unsorted_double_ended_priority_queue_unit #(
  parameter int DEPTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // value[31:0]
  input  wire logic [1:0]  s_tuser,   // operation[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // result_value[31:0], occupancy[38:32], zero[39]
  output logic [1:0]       m_tuser    // status[1:0]
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int POS_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t                              state, state_next;
  logic [CNT_W-1:0]                    count;
  logic [POS_W-1:0]                    pos;
  logic                                is_insert;
  logic                                want_max;
  logic                                accept;
  logic                                out_free;
  logic                                load_out;
  logic signed [udepq_pkg::DATA_W-1:0] out_value;
  logic [1:0]                          out_status;
  logic [udepq_pkg::OCC_W-1:0]         out_occ;
  logic                                res_load;
  logic signed [udepq_pkg::DATA_W-1:0] res_value;
  logic [1:0]                          res_status;
  logic [CNT_W-1:0]                    res_count;
  logic                                start_scan;
  logic                                full;
  logic                                empty;
  logic                                held_valid;
  logic signed [udepq_pkg::DATA_W-1:0] held_data;
  udepq_pkg::scan_ctrl_t               ctrl;
  udepq_pkg::cell_t                    ring [DEPTH];
  udepq_pkg::cell_t                    head_out;
  logic [DEPTH-1:0]                    occ_map;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE) && out_free;
  assign accept   = s_tvalid && s_tready;
  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);

  always_comb begin
    start_scan = 1'b0;
    res_load   = 1'b0;
    res_value  = '0;
    res_status = udepq_pkg::STAT_OK;
    res_count  = count;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (s_tuser)
            udepq_pkg::OP_INSERT: begin
              if (full) begin
                res_load   = 1'b1;
                res_status = udepq_pkg::STAT_FULL;
              end else begin
                start_scan = 1'b1;
              end
            end
            udepq_pkg::OP_MAX, udepq_pkg::OP_MIN: begin
              if (empty) begin
                res_load   = 1'b1;
                res_status = udepq_pkg::STAT_EMPTY;
              end else begin
                start_scan = 1'b1;
              end
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
          if (start_scan) begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (pos == POS_W'(DEPTH - 1)) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          res_load   = 1'b1;
          res_value  = is_insert ? '0 : held_data;
          res_count  = is_insert ? count + 1'b1 : count - 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= res_count;
    end
  end

  always_ff @(posedge clk) begin
    if (start_scan) begin
      pos       <= '0;
      is_insert <= (s_tuser == udepq_pkg::OP_INSERT);
      want_max  <= (s_tuser == udepq_pkg::OP_MAX);
    end else if (state == S_SCAN) begin
      pos <= pos + 1'b1;
    end
  end

  assign load_out = res_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_value  <= res_value;
      out_status <= res_status;
      out_occ    <= udepq_pkg::OCC_W'(res_count);
    end
  end

  assign m_tdata = {1'b0, out_occ, out_value};
  assign m_tuser = out_status;

  assign ctrl.load     = start_scan;
  assign ctrl.shift    = (state == S_SCAN);
  assign ctrl.insert   = start_scan ? (s_tuser == udepq_pkg::OP_INSERT) : is_insert;
  assign ctrl.want_max = want_max;

  udepq_head u_head (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .value      (s_tdata),
    .ring_in    (ring[0]),
    .ring_out   (head_out),
    .held_valid (held_valid),
    .held_data  (held_data)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == DEPTH - 1) begin : g_tail
      udepq_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (ctrl.shift),
        .din   (head_out),
        .dout  (ring[i])
      );
    end else begin : g_body
      udepq_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (ctrl.shift),
        .din   (ring[i+1]),
        .dout  (ring[i])
      );
    end
    assign occ_map[i] = ring[i].valid;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("occupancy count beyond depth");

  a_map_matches: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> ($countones(occ_map) == int'(count)))
    else $error("occupied cells disagree with count");

  a_extract_found: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && !is_insert) |-> held_valid)
    else $error("extract pass found no entry");

  a_insert_placed: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && is_insert) |-> !held_valid)
    else $error("insert pass found no free cell");

endmodule

`default_nettype wire

@@ bench/unsorted_double_ended_priority_queue_unit_tb.sv @@
`timescale 1ns / 100ps
// testbench for unsorted_double_ended_priority_queue_unit: directed table, then phased random
// insert/extract traffic checked against a shadow queue; depends on udepq_pkg and the unit

module unsorted_double_ended_priority_queue_unit_tb;

  localparam int DEPTH = 64;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int NUM_DIRECTED = 23;
  localparam int NUM_PHASES = 7;
  localparam int PHASE_LEN = 75;
  localparam int CALM_ITEMS = 60;
  localparam int HOLD_CYCLES = 500;

  typedef struct packed {
    logic signed [udepq_pkg::DATA_W-1:0] value;
    logic [1:0]                          status;
    logic [udepq_pkg::OCC_W-1:0]         occupancy;
  } op_result_t;

  typedef struct packed {
    logic [1:0]                   op;
    logic [udepq_pkg::DATA_W-1:0] val;
    logic                         typed;
    logic [udepq_pkg::DATA_W-1:0] res_val;
    logic [1:0]                   res_stat;
    logic [udepq_pkg::OCC_W-1:0]  res_occ;
  } dir_row_t;

  localparam dir_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    '{udepq_pkg::OP_MAX,    32'h0000_0000, 1'b1, 32'h0000_0000, udepq_pkg::STAT_EMPTY, 7'd0},
    '{udepq_pkg::OP_MIN,    32'h0000_3039, 1'b1, 32'h0000_0000, udepq_pkg::STAT_EMPTY, 7'd0},
    '{OP_UNUSED,            32'hffff_ffff, 1'b1, 32'h0000_0000, udepq_pkg::STAT_OK,    7'd0},
    '{udepq_pkg::OP_INSERT, 32'h7fff_ffff, 1'b1, 32'h0000_0000, udepq_pkg::STAT_OK,    7'd1},
    '{udepq_pkg::OP_INSERT, 32'h8000_0000, 1'b1, 32'h0000_0000, udepq_pkg::STAT_OK,    7'd2},
    '{udepq_pkg::OP_INSERT, 32'h0000_0000, 1'b1, 32'h0000_0000, udepq_pkg::STAT_OK,    7'd3},
    '{OP_UNUSED,            32'h5555_5555, 1'b1, 32'h0000_0000, udepq_pkg::STAT_OK,    7'd3},
    '{udepq_pkg::OP_MAX,    32'h0000_0000, 1'b1, 32'h7fff_ffff, udepq_pkg::STAT_OK,    7'd2},
    '{udepq_pkg::OP_MIN,    32'hffff_ffff, 1'b1, 32'h8000_0000, udepq_pkg::STAT_OK,    7'd1},
    '{udepq_pkg::OP_MAX,    32'h0000_0000, 1'b1, 32'h0000_0000, udepq_pkg::STAT_OK,    7'd0},
    '{udepq_pkg::OP_INSERT, 32'hffff_ffff, 1'b1, 32'h0000_0000, udepq_pkg::STAT_OK,    7'd1},
    '{udepq_pkg::OP_INSERT, 32'h0000_0005, 1'b1, 32'h0000_0000, udepq_pkg::STAT_OK,    7'd2},
    '{udepq_pkg::OP_INSERT, 32'hffff_ffff, 1'b1, 32'h0000_0000, udepq_pkg::STAT_OK,    7'd3},
    '{udepq_pkg::OP_INSERT, 32'h0000_0005, 1'b1, 32'h0000_0000, udepq_pkg::STAT_OK,    7'd4},
    '{udepq_pkg::OP_MIN,    32'h0000_0000, 1'b0, 32'h0000_0000, udepq_pkg::STAT_OK,    7'd0},
    '{udepq_pkg::OP_MAX,    32'h0000_0000, 1'b0, 32'h0000_0000, udepq_pkg::STAT_OK,    7'd0},
    '{udepq_pkg::OP_MIN,    32'h0000_0000, 1'b0, 32'h0000_0000, udepq_pkg::STAT_OK,    7'd0},
    '{udepq_pkg::OP_MAX,    32'h0000_0000, 1'b0, 32'h0000_0000, udepq_pkg::STAT_OK,    7'd0},
    '{udepq_pkg::OP_MIN,    32'h0000_0000, 1'b1, 32'h0000_0000, udepq_pkg::STAT_EMPTY, 7'd0},
    '{udepq_pkg::OP_INSERT, 32'haaaa_aaaa, 1'b0, 32'h0000_0000, udepq_pkg::STAT_OK,    7'd0},
    '{udepq_pkg::OP_INSERT, 32'h5555_5555, 1'b0, 32'h0000_0000, udepq_pkg::STAT_OK,    7'd0},
    '{udepq_pkg::OP_MAX,    32'h0000_0000, 1'b0, 32'h0000_0000, udepq_pkg::STAT_OK,    7'd0},
    '{udepq_pkg::OP_MIN,    32'h0000_0000, 1'b0, 32'h0000_0000, udepq_pkg::STAT_OK,    7'd0}
  };

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [31:0]       s_tdata = '0;
  logic [1:0]        s_tuser = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [39:0]       m_tdata;
  logic [1:0]        m_tuser;

  logic signed [udepq_pkg::DATA_W-1:0] shadow_vals [DEPTH];
  int                                  shadow_count = 0;
  op_result_t                          pending_results [$];
  int                                  errors = 0;
  int                                  sent_count = 0;
  bit                                  calm = 1'b0;

  unsorted_double_ended_priority_queue_unit #(.DEPTH(DEPTH)) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  function automatic op_result_t apply_to_shadow(logic [1:0] op,
                                                 logic signed [udepq_pkg::DATA_W-1:0] val);
    op_result_t r;
    int best;
    r = '0;
    case (op)
      udepq_pkg::OP_INSERT: begin
        if (shadow_count >= DEPTH) begin
          r.status = udepq_pkg::STAT_FULL;
        end else begin
          shadow_vals[shadow_count] = val;
          shadow_count++;
        end
      end
      udepq_pkg::OP_MAX, udepq_pkg::OP_MIN: begin
        if (shadow_count == 0) begin
          r.status = udepq_pkg::STAT_EMPTY;
        end else begin
          best = 0;
          for (int i = 1; i < shadow_count; i++) begin
            if (op == udepq_pkg::OP_MAX ? (shadow_vals[i] > shadow_vals[best])
                                        : (shadow_vals[i] < shadow_vals[best]))
              best = i;
          end
          r.value = shadow_vals[best];
          shadow_vals[best] = shadow_vals[shadow_count-1];
          shadow_count--;
        end
      end
      default: ;
    endcase
    r.occupancy = shadow_count[udepq_pkg::OCC_W-1:0];
    return r;
  endfunction

  function automatic logic [udepq_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2, 3:    return 32'($signed($urandom_range(0, 8)) - 4);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [1:0] pick_op(int ins_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < 2) return OP_UNUSED;
    if (r < 2 + ins_pct) return udepq_pkg::OP_INSERT;
    return $urandom_range(0, 1) ? udepq_pkg::OP_MAX : udepq_pkg::OP_MIN;
  endfunction

  task automatic send_op(input logic [1:0] op, input logic [udepq_pkg::DATA_W-1:0] val,
                         input logic typed, input op_result_t typed_res);
    op_result_t predicted;
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= val;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = apply_to_shadow(op, val);
    pending_results.push_back(typed ? typed_res : predicted);
    sent_count++;
  endtask

  // stimulus
  initial begin
    dir_row_t row;
    op_result_t row_res;
    int ins_pct;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      row = DIRECTED_ROWS[i];
      row_res.value     = row.res_val;
      row_res.status    = row.res_stat;
      row_res.occupancy = row.res_occ;
      send_op(row.op, row.val, row.typed, row_res);
    end
    // fill, drain and mixed phases so that full and empty are both hit
    for (int p = 0; p < NUM_PHASES; p++) begin
      ins_pct = (p % 3 == 0) ? 97 : (p % 3 == 1) ? 3 : 48;
      for (int k = 0; k < PHASE_LEN; k++) begin
        if (sent_count >= NUM_DIRECTED + NUM_PHASES * PHASE_LEN - CALM_ITEMS) calm = 1'b1;
        send_op(pick_op(ins_pct), pick_value(), 1'b0, '0);
      end
    end
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // result side backpressure, with one long hold-off that stalls the queue behind a waiting result
  initial begin
    bit held;
    held = 1'b0;
    repeat (12) @(posedge clk);
    forever begin
      @(posedge clk);
      if (!held && sent_count >= NUM_DIRECTED + 10) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        m_tready <= 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    op_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected transfer, expected none, actual data %h status %0d",
                 $time, m_tdata, m_tuser);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[31:0] !== want.value) begin
          $display("%0t: result_value expected %0d actual %0d",
                   $time, want.value, $signed(m_tdata[31:0]));
          errors++;
        end
        if (m_tuser !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, m_tuser);
          errors++;
        end
        if (m_tdata[38:32] !== want.occupancy) begin
          $display("%0t: occupancy expected %0d actual %0d",
                   $time, want.occupancy, m_tdata[38:32]);
          errors++;
        end
      end
    end
  end

  initial begin
    #3_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

@@ filelist.f @@
design/udepq_pkg.sv
design/udepq_cell.sv
design/udepq_head.sv
design/unsorted_double_ended_priority_queue_unit.sv
bench/unsorted_double_ended_priority_queue_unit_tb.sv
